// File: rtl/mls_pkg.sv
`timescale 1ns / 1ps

package mls_pkg;

  // Widths of the counters and limits.
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned RCNT_W  = 8;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 10;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_READY_LIMIT = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_FIRST_LIMIT = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_LONG_LIMIT  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_RESETS_MAX  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_STALE_LIMIT = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_GPS_LIMIT   = 3'd5;

  // Register values after reset.
  localparam logic [CNT_W-1:0]  RST_READY_LIMIT = 10'd120;
  localparam logic [CNT_W-1:0]  RST_FIRST_LIMIT = 10'd180;
  localparam logic [CNT_W-1:0]  RST_LONG_LIMIT  = 10'd900;
  localparam logic [RCNT_W-1:0] RST_RESETS_MAX  = 8'd5;
  localparam logic [CNT_W-1:0]  RST_STALE_LIMIT = 10'd10;
  localparam logic [CNT_W-1:0]  RST_GPS_LIMIT   = 10'd300;

  // Request kinds.
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Buzzer codes as reported by the device.
  localparam logic [1:0] BUZ_NONE      = 2'd0;
  localparam logic [1:0] BUZ_OVERSPEED = 2'd1;
  localparam logic [1:0] BUZ_OVERTIME  = 2'd2;

  // Buzzer commands.
  localparam logic [1:0] CMD_NO_CHANGE    = 2'd0;
  localparam logic [1:0] CMD_SET_NONE     = 2'd1;
  localparam logic [1:0] CMD_SET_OVERSPD  = 2'd2;
  localparam logic [1:0] CMD_SET_OVERTIME = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]  ready_silence_limit;
    logic [CNT_W-1:0]  first_crash_limit;
    logic [CNT_W-1:0]  long_crash_limit;
    logic [RCNT_W-1:0] resets_before_crash;
    logic [CNT_W-1:0]  stale_limit;
    logic [CNT_W-1:0]  gps_loss_limit;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  silence_count;
    logic              ready_flag;
    logic              crash_flag;
    logic [RCNT_W-1:0] reset_count;
    logic              long_backoff;
    logic [2:0]        status_bits;
    logic [CNT_W-1:0]  gps_loss_count;
    logic [1:0]        previous_buzzer;
  } state_t;

  typedef struct packed {
    logic       req_type;
    logic       frame_marked;
    logic       status_update;
    logic       gps_fix;
    logic       over_speed;
    logic       drive_overtime;
    logic       low_power;
    logic [1:0] buzzer_now;
  } item_t;

  typedef struct packed {
    logic [1:0]        buzzer_command;
    logic              modem_reset;
    logic              battery_off;
    logic              crashed;
    logic [RCNT_W-1:0] reset_total;
  } result_t;

  // True for the buzzer codes that sound an alarm.
  function automatic logic alarm_buzz(input logic [1:0] b);
    return (b == BUZ_OVERSPEED) || (b == BUZ_OVERTIME);
  endfunction

endpackage

// File: rtl/mls_cfg.sv
`timescale 1ns / 1ps

module mls_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [mls_pkg::CIDX_W-1:0]   wr_index,
  input  logic [mls_pkg::CDATA_W-1:0]  wr_data,
  output mls_pkg::cfg_t                cfg_o
);

  mls_pkg::cfg_t cfg_r;

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_silence_limit <= mls_pkg::RST_READY_LIMIT;
      cfg_r.first_crash_limit   <= mls_pkg::RST_FIRST_LIMIT;
      cfg_r.long_crash_limit    <= mls_pkg::RST_LONG_LIMIT;
      cfg_r.resets_before_crash <= mls_pkg::RST_RESETS_MAX;
      cfg_r.stale_limit         <= mls_pkg::RST_STALE_LIMIT;
      cfg_r.gps_loss_limit      <= mls_pkg::RST_GPS_LIMIT;
    end else if (wr_en) begin
      unique case (wr_index)
        mls_pkg::CFG_READY_LIMIT: cfg_r.ready_silence_limit <= wr_data;
        mls_pkg::CFG_FIRST_LIMIT: cfg_r.first_crash_limit   <= wr_data;
        mls_pkg::CFG_LONG_LIMIT:  cfg_r.long_crash_limit    <= wr_data;
        mls_pkg::CFG_RESETS_MAX:  cfg_r.resets_before_crash <= wr_data[mls_pkg::RCNT_W-1:0];
        mls_pkg::CFG_STALE_LIMIT: cfg_r.stale_limit         <= wr_data;
        mls_pkg::CFG_GPS_LIMIT:   cfg_r.gps_loss_limit      <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: rtl/mls_step.sv
`timescale 1ns / 1ps

module mls_step (
  input  mls_pkg::cfg_t   cfg_i,
  input  mls_pkg::state_t st_i,
  input  mls_pkg::item_t  item_i,
  output mls_pkg::state_t st_o,
  output mls_pkg::result_t res_o
);

  localparam logic [mls_pkg::CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [mls_pkg::RCNT_W-1:0] RCNT_MAX = '1;

  always_comb begin
    mls_pkg::state_t       st;
    logic [1:0]            cmd;
    logic                  mreset;
    logic                  batoff;
    logic                  do_reset;
    logic [mls_pkg::CNT_W-1:0] lim;

    st       = st_i;
    cmd      = mls_pkg::CMD_NO_CHANGE;
    mreset   = 1'b0;
    batoff   = 1'b0;
    do_reset = 1'b0;
    lim      = st_i.long_backoff ? cfg_i.long_crash_limit : cfg_i.first_crash_limit;

    if (item_i.req_type == mls_pkg::REQ_FRAME) begin
      // Any frame ends the silence; a marked one proves the modem alive.
      st.silence_count = '0;
      if (item_i.frame_marked) begin
        if (item_i.status_update) begin
          st.status_bits = {item_i.drive_overtime, item_i.over_speed, item_i.gps_fix};
        end
        st.ready_flag = 1'b1;
        st.crash_flag = 1'b0;
      end
    end else begin
      // Tick: count silence and check it against the limit in force.
      if (st.silence_count != CNT_MAX) begin
        st.silence_count = st.silence_count + 10'd1;
      end
      if (!st_i.crash_flag && st_i.ready_flag) begin
        if (mls_pkg::alarm_buzz(st_i.previous_buzzer)) begin
          cmd = mls_pkg::CMD_SET_NONE;
        end
        do_reset = (st.silence_count >= cfg_i.ready_silence_limit);
      end else begin
        do_reset = (st.silence_count >= lim);
        if (do_reset) begin
          st.long_backoff = 1'b1;
        end
      end
      if (do_reset) begin
        st.silence_count = '0;
        st.status_bits   = '0;
        mreset           = 1'b1;
        if (st.reset_count != RCNT_MAX) begin
          st.reset_count = st.reset_count + 8'd1;
        end
        if (!st_i.crash_flag && st_i.ready_flag &&
            (st.reset_count > cfg_i.resets_before_crash)) begin
          st.crash_flag = 1'b1;
        end
      end
      // Old status is dropped once the link has been quiet too long.
      if (st.silence_count > cfg_i.stale_limit) begin
        st.status_bits = '0;
      end
    end

    // Buzzer and GPS-loss handling on every item.
    if (st.status_bits[0]) begin
      if (st.status_bits[1]) begin
        cmd = mls_pkg::CMD_SET_OVERSPD;
      end else if (st.status_bits[2]) begin
        cmd = mls_pkg::CMD_SET_OVERTIME;
      end else if (mls_pkg::alarm_buzz(item_i.buzzer_now)) begin
        cmd = mls_pkg::CMD_SET_NONE;
      end
      st.gps_loss_count = '0;
    end else begin
      if (mls_pkg::alarm_buzz(item_i.buzzer_now)) begin
        cmd = mls_pkg::CMD_SET_NONE;
      end
      if (item_i.low_power) begin
        if (st.gps_loss_count != CNT_MAX) begin
          st.gps_loss_count = st.gps_loss_count + 10'd1;
        end
        if (st.gps_loss_count >= cfg_i.gps_loss_limit) begin
          st.gps_loss_count = '0;
          batoff            = 1'b1;
        end
      end
    end
    st.previous_buzzer = item_i.buzzer_now;

    st_o                 = st;
    res_o.buzzer_command = cmd;
    res_o.modem_reset    = mreset;
    res_o.battery_off    = batoff;
    res_o.crashed        = st.crash_flag;
    res_o.reset_total    = st.reset_count;
  end

endmodule

// File: rtl/modem_link_supervisor_unit.sv
`timescale 1ns / 1ps

// Modem link supervisor.
// Items arrive on the in_ channel: in_tuser says what the item is (0 a received
// frame, 1 a one-second tick with no frame) and in_tdata carries the frame flags,
// the status bits, the power-save flag and the current buzzer code. Every item
// yields exactly one result beat on the out_ channel with the buzzer command,
// the modem reset pulse, the battery-off request, the crash flag and the count
// of modem resets issued so far.
// An item passes through an input register and then one step of compare and
// count logic into the output register, which holds its result beat.
// One item is taken every cycle as long as results drain.
// When the receiver stalls the result waits in the output register and one more
// item can sit in the input register; in_tready falls only when both are full.
// The cfg_ channel writes the six limit registers; it is always ready. The user
// must use it only while no item is in flight; the block does not enforce this.
// Reset clears all counters and flags, empties both registers and loads the
// limit registers with their default values.
module modem_link_supervisor_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // frame_marked, status_update, gps_fix, over_speed,
                                  // drive_overtime, low_power, buzzer_now[1:0]
  input  logic        in_tuser,   // req_type
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // buzzer_command[1:0], modem_reset, battery_off,
                                  // crashed, reset_total[7:0], zero fill
  // Configuration write channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mls_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [mls_pkg::CDATA_W-1:0] cfg_data
);

  mls_pkg::cfg_t    cfg;
  mls_pkg::state_t  st_r;
  mls_pkg::state_t  st_nxt;
  mls_pkg::item_t   in_item_r;
  mls_pkg::result_t res_nxt;
  mls_pkg::result_t out_res_r;
  logic             in_valid_r;
  logic             out_valid_r;
  logic             advance;

  assign cfg_ready = 1'b1;

  mls_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_o    (cfg)
  );

  mls_step u_step (
    .cfg_i  (cfg),
    .st_i   (st_r),
    .item_i (in_item_r),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  // The held item moves on whenever the output register is free or draining.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.req_type       <= in_tuser;
      in_item_r.frame_marked   <= in_tdata[0];
      in_item_r.status_update  <= in_tdata[1];
      in_item_r.gps_fix        <= in_tdata[2];
      in_item_r.over_speed     <= in_tdata[3];
      in_item_r.drive_overtime <= in_tdata[4];
      in_item_r.low_power      <= in_tdata[5];
      in_item_r.buzzer_now     <= in_tdata[7:6];
    end
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.reset_total, out_res_r.crashed,
                       out_res_r.battery_off, out_res_r.modem_reset,
                       out_res_r.buzzer_command};

endmodule

// File: rtl/mls_checker.sv
`timescale 1ns / 1ps

module mls_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A result waiting on a stalled receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // No result appears in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The crash flag only comes from an issued reset, and resets are never uncounted.
  a_crash_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[12:5] != 8'd0)
    else $error("crash flag with zero reset count");

  // A reset pulse is always included in the count it reports.
  a_reset_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[12:5] != 8'd0)
    else $error("modem reset with zero reset count");

  // Fill bits above the fields stay zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:13] == 3'b000)
    else $error("fill bits of result beat not zero");

endmodule

bind modem_link_supervisor_unit mls_checker u_mls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/sv/tb_modem_link_supervisor_unit.sv
`timescale 1ns / 1ps

module tb_modem_link_supervisor_unit;

  // Buzzer code with no name in the package, and a register index that maps to nothing.
  localparam logic [1:0]                 BUZ_OTHER      = 2'd3;
  localparam logic [mls_pkg::CIDX_W-1:0] CFG_NO_REG     = 3'd6;
  localparam int unsigned                WATCHDOG_LIMIT = 3000;
  localparam int unsigned                HOLD_AFTER     = 50;
  localparam int unsigned                HOLD_CYCLES    = 80;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [7:0]                   in_tdata = '0;
  logic                         in_tuser = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [15:0]                  out_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [mls_pkg::CIDX_W-1:0]   cfg_index = '0;
  logic [mls_pkg::CDATA_W-1:0]  cfg_data = '0;

  // Items waiting for the driver, and results owed by the block.
  mls_pkg::item_t   pending_items[$];
  mls_pkg::result_t owed_results[$];
  mls_pkg::item_t   offered = '0;
  int unsigned      mismatches = 0;
  int unsigned      cycle_no = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      results_taken = 0;
  int unsigned      hold_left = 0;
  bit               hold_done = 1'b0;

  // Mirror of the limit registers.
  logic [mls_pkg::CNT_W-1:0]  lim_ready, lim_first, lim_long, lim_stale, lim_gps;
  logic [mls_pkg::RCNT_W-1:0] lim_resets;

  // Mirror of the supervisor state.
  logic [mls_pkg::CNT_W-1:0]  quiet_ticks;
  logic                       link_up, link_dead, backoff_long;
  logic [mls_pkg::RCNT_W-1:0] reboots;
  logic [2:0]                 modem_status;
  logic [mls_pkg::CNT_W-1:0]  no_fix_ticks;
  logic [1:0]                 last_buzzer;

  modem_link_supervisor_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Random idling, switched off over one long stretch of the run.
  function automatic bit take_break();
    if (cycle_no >= 600 && cycle_no < 1100) return 1'b0;
    return $urandom_range(99) < 7;
  endfunction

  // A modem reset clears silence and status and counts up, saturating.
  function automatic void reboot_modem();
    quiet_ticks  = '0;
    modem_status = '0;
    if (reboots != '1) reboots = reboots + 8'd1;
  endfunction

  // Advance the mirrored state by one item and return the result it owes.
  function automatic mls_pkg::result_t supervise_step(input mls_pkg::item_t it);
    mls_pkg::result_t          r;
    logic [mls_pkg::CNT_W-1:0] lim;
    r = '0;
    r.buzzer_command = mls_pkg::CMD_NO_CHANGE;
    if (it.req_type == mls_pkg::REQ_FRAME) begin
      quiet_ticks = '0;
      if (it.frame_marked) begin
        if (it.status_update) modem_status = {it.drive_overtime, it.over_speed, it.gps_fix};
        link_up   = 1'b1;
        link_dead = 1'b0;
      end
    end else begin
      if (quiet_ticks != '1) quiet_ticks = quiet_ticks + 10'd1;
      if (!link_dead && link_up) begin
        if (last_buzzer == mls_pkg::BUZ_OVERSPEED || last_buzzer == mls_pkg::BUZ_OVERTIME)
          r.buzzer_command = mls_pkg::CMD_SET_NONE;
        if (quiet_ticks >= lim_ready) begin
          reboot_modem();
          r.modem_reset = 1'b1;
          if (reboots > lim_resets) link_dead = 1'b1;
        end
      end else begin
        lim = backoff_long ? lim_long : lim_first;
        if (quiet_ticks >= lim) begin
          backoff_long = 1'b1;
          reboot_modem();
          r.modem_reset = 1'b1;
        end
      end
      if (quiet_ticks > lim_stale) modem_status = '0;
    end

    // Buzzer follows the stored status; without a fix, power save counts GPS loss.
    if (modem_status[0]) begin
      if (modem_status[1])
        r.buzzer_command = mls_pkg::CMD_SET_OVERSPD;
      else if (modem_status[2])
        r.buzzer_command = mls_pkg::CMD_SET_OVERTIME;
      else if (it.buzzer_now == mls_pkg::BUZ_OVERSPEED ||
               it.buzzer_now == mls_pkg::BUZ_OVERTIME)
        r.buzzer_command = mls_pkg::CMD_SET_NONE;
      no_fix_ticks = '0;
    end else begin
      if (it.buzzer_now == mls_pkg::BUZ_OVERSPEED || it.buzzer_now == mls_pkg::BUZ_OVERTIME)
        r.buzzer_command = mls_pkg::CMD_SET_NONE;
      if (it.low_power) begin
        if (no_fix_ticks != '1) no_fix_ticks = no_fix_ticks + 10'd1;
        if (no_fix_ticks >= lim_gps) begin
          no_fix_ticks  = '0;
          r.battery_off = 1'b1;
        end
      end
    end
    last_buzzer   = it.buzzer_now;
    r.crashed     = link_dead;
    r.reset_total = reboots;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Input driver: a new beat is offered once the previous one is taken.
  always @(posedge clk) begin : drive_items
    mls_pkg::item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_items.size() != 0 && !take_break()) begin
        nxt = pending_items.pop_front();
        offered   <= nxt;
        in_tuser  <= nxt.req_type;
        in_tdata  <= {nxt.buzzer_now, nxt.low_power, nxt.drive_overtime, nxt.over_speed,
                      nxt.gps_fix, nxt.status_update, nxt.frame_marked};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side ready, with one long hold-off that lets the block fill up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) results_taken++;
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !take_break();
      end
    end
  end

  // Monitor: check result beats, then track register writes and accepted items.
  always @(posedge clk) begin : monitor
    mls_pkg::result_t want;
    if (!rst_n) begin
      lim_ready    = mls_pkg::RST_READY_LIMIT;
      lim_first    = mls_pkg::RST_FIRST_LIMIT;
      lim_long     = mls_pkg::RST_LONG_LIMIT;
      lim_resets   = mls_pkg::RST_RESETS_MAX;
      lim_stale    = mls_pkg::RST_STALE_LIMIT;
      lim_gps      = mls_pkg::RST_GPS_LIMIT;
      quiet_ticks  = '0;
      link_up      = 1'b0;
      link_dead    = 1'b0;
      backoff_long = 1'b0;
      reboots      = '0;
      modem_status = '0;
      no_fix_ticks = '0;
      last_buzzer  = mls_pkg::BUZ_NONE;
      owed_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          $error("result beat with no expectation waiting: %h", out_tdata);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("buzzer_command", 32'(want.buzzer_command), 32'(out_tdata[1:0]));
          check_field("modem_reset",    32'(want.modem_reset),    32'(out_tdata[2]));
          check_field("battery_off",    32'(want.battery_off),    32'(out_tdata[3]));
          check_field("crashed",        32'(want.crashed),        32'(out_tdata[4]));
          check_field("reset_total",    32'(want.reset_total),    32'(out_tdata[12:5]));
          check_field("zero_fill",      32'd0,                    32'(out_tdata[15:13]));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mls_pkg::CFG_READY_LIMIT: lim_ready  = cfg_data;
          mls_pkg::CFG_FIRST_LIMIT: lim_first  = cfg_data;
          mls_pkg::CFG_LONG_LIMIT:  lim_long   = cfg_data;
          mls_pkg::CFG_RESETS_MAX:  lim_resets = cfg_data[mls_pkg::RCNT_W-1:0];
          mls_pkg::CFG_STALE_LIMIT: lim_stale  = cfg_data;
          mls_pkg::CFG_GPS_LIMIT:   lim_gps    = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) owed_results.push_back(supervise_step(offered));
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** modem_link_supervisor_unit: FAILED **");
      $finish;
    end
  end

  task automatic add_item(input logic req, input logic marked, input logic upd,
                          input logic gps, input logic ovs, input logic drv,
                          input logic psave, input logic [1:0] buz);
    mls_pkg::item_t it;
    it.req_type       = req;
    it.frame_marked   = marked;
    it.status_update  = upd;
    it.gps_fix        = gps;
    it.over_speed     = ovs;
    it.drive_overtime = drv;
    it.low_power      = psave;
    it.buzzer_now     = buz;
    pending_items.push_back(it);
  endtask

  // Random items: mostly ticks and marked frames, with unmarked frames as noise.
  task automatic add_random(input int unsigned n, input int unsigned tick_pct,
                            input int unsigned marked_pct, input int unsigned psave_pct);
    repeat (n) begin
      add_item(($urandom_range(99) < tick_pct) ? mls_pkg::REQ_TICK : mls_pkg::REQ_FRAME,
               $urandom_range(99) < marked_pct, $urandom_range(99) < 70,
               1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
               $urandom_range(99) < psave_pct, 2'($urandom_range(3)));
    end
  endtask

  task automatic write_reg(input logic [mls_pkg::CIDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[mls_pkg::CDATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input int unsigned ready, input int unsigned first,
                            input int unsigned long_lim, input int unsigned resets,
                            input int unsigned stale, input int unsigned gps);
    write_reg(mls_pkg::CFG_READY_LIMIT, ready);
    write_reg(mls_pkg::CFG_FIRST_LIMIT, first);
    write_reg(mls_pkg::CFG_LONG_LIMIT,  long_lim);
    write_reg(mls_pkg::CFG_RESETS_MAX,  resets);
    write_reg(mls_pkg::CFG_STALE_LIMIT, stale);
    write_reg(mls_pkg::CFG_GPS_LIMIT,   gps);
    @(negedge clk);
  endtask

  // Wait until every item is taken and every result has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || owed_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items with the reset limits.
    // Tick before the link is up.
    add_item(mls_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, mls_pkg::BUZ_OVERSPEED);
    // Status on an unmarked frame.
    add_item(mls_pkg::REQ_FRAME, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, mls_pkg::BUZ_NONE);
    // Frame fields on a tick.
    add_item(mls_pkg::REQ_TICK, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, mls_pkg::BUZ_OVERTIME);
    // Fix with over-speed.
    add_item(mls_pkg::REQ_FRAME, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, mls_pkg::BUZ_NONE);
    // Fix with drive overtime.
    add_item(mls_pkg::REQ_FRAME, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, BUZ_OTHER);
    // Fix only, alarm sounding.
    add_item(mls_pkg::REQ_FRAME, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, mls_pkg::BUZ_OVERSPEED);
    // Alarm left over from the last step.
    add_item(mls_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, mls_pkg::BUZ_OVERTIME);
    add_item(mls_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, BUZ_OTHER);
    // Status without a fix.
    add_item(mls_pkg::REQ_FRAME, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, BUZ_OTHER);
    // Marked frame, no status.
    add_item(mls_pkg::REQ_FRAME, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, mls_pkg::BUZ_NONE);
    add_item(mls_pkg::REQ_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, mls_pkg::BUZ_NONE);
    add_item(mls_pkg::REQ_FRAME, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, mls_pkg::BUZ_OVERSPEED);
    // Status goes stale.
    for (int i = 0; i < 12; i++)
      add_item(mls_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 2'(i % 4));
    add_random(100, 70, 80, 50);
    wait_idle();

    // Low limits: resets after short silences, early crash and backoff.
    set_limits(1, 1, 2, 0, 0, 1);
    add_random(150, 60, 70, 50);
    wait_idle();

    // Highest limits: long quiet runs without a reset or a battery-off request.
    set_limits(1023, 1023, 1023, 1023, 1023, 1023);
    add_item(mls_pkg::REQ_FRAME, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, mls_pkg::BUZ_NONE);
    add_random(360, 100, 0, 100);
    wait_idle();

    // Reset count driven into saturation, then mixed traffic.
    set_limits(1, 2, 3, 255, 2, 5);
    add_item(mls_pkg::REQ_FRAME, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, mls_pkg::BUZ_NONE);
    add_random(260, 100, 0, 50);
    add_random(100, 80, 60, 50);
    wait_idle();

    // Middle limits, plus a write to an index with no register behind it.
    set_limits(20, 15, 40, 3, 5, 12);
    write_reg(CFG_NO_REG, 7);
    @(negedge clk);
    add_random(200, 85, 50, 50);
    wait_idle();

    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("** modem_link_supervisor_unit: PASSED **");
    else
      $display("** modem_link_supervisor_unit: FAILED **");
    $finish;
  end

endmodule
